// ===== sv/pbet_pkg.sv =====
// ---------------------------------------------------------------------------
// pbet_pkg: shared types and constants of the peer backoff expiry table
// Item structs, configuration block, front-to-back queue entry, action and
// register codes, and the effective interval helper.
// ---------------------------------------------------------------------------
package pbet_pkg;

  // Input action codes
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_QUERY  = 2'd1;
  localparam logic [1:0] ACT_UPDATE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_IDX_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_IDX_PRUNE    = 2'd1;
  localparam logic [1:0] CFG_IDX_SLACK    = 2'd2;

  // Configuration reset values
  localparam logic [15:0] RST_INTERVAL = 16'd1000;
  localparam logic [23:0] RST_PRUNE    = 24'd60000;
  localparam logic [7:0]  RST_SLACK    = 8'd1;

  // Work kinds handed from front to back
  localparam logic [1:0] KIND_NOP    = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;
  localparam logic [1:0] KIND_UPDATE = 2'd3;

  // Divider steps: one quotient bit per cycle over the backoff time and the default backoff
  localparam int DIV_STEPS = 24;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  peer_index;
    logic [23:0] backoff_time;
    logic        use_default;
  } in_item_t;

  typedef struct packed {
    logic [31:0] remaining_slots;
    logic [31:0] remaining_time;
    logic        in_backoff;
  } out_item_t;

  typedef struct packed {
    logic [15:0] hb_period;
    logic [23:0] dflt_backoff;
    logic [7:0]  extra_slots;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  peer;
    logic [24:0] slots;
  } q_entry_t;

  // A zero interval counts as one
  function automatic logic [15:0] eff_interval(input logic [15:0] iv);
    eff_interval = (iv == 16'd0) ? 16'd1 : iv;
  endfunction

endpackage

// ===== sv/peer_backoff_expiry_table.sv =====
// ---------------------------------------------------------------------------
// peer_backoff_expiry_table: per-peer backoff tracker for one topic
// Order, accepting edge to the result strobe: front (the divider, for an update
// only), queue, then back (evaluate; a query also multiplies and finishes).
// The front takes no new item until it has pushed the last, and an update holds
// it in the divider; other items are limited by the table sequencer.
// Reset: busy stays high for NUM_PEERS cycles while the expiry memory clears.
// Every item gives exactly one result strobe; the receiver cannot stall.
// ---------------------------------------------------------------------------
module peer_backoff_expiry_table
  import pbet_pkg::*;
#(
  parameter int NUM_PEERS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  cfg_t     cfg_r, cfg_nxt;
  logic     front_busy;
  logic     clearing;
  logic     push_valid, push_ready;
  q_entry_t push_entry;
  logic     pop_valid, pop;
  q_entry_t pop_entry;

  assign cfg_ready = 1'b1;
  assign busy      = front_busy || clearing;

  // Decode configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_INTERVAL: cfg_nxt.hb_period    = cfg_data[15:0];
        CFG_IDX_PRUNE:    cfg_nxt.dflt_backoff = cfg_data;
        CFG_IDX_SLACK:    cfg_nxt.extra_slots  = cfg_data[7:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hb_period    <= RST_INTERVAL;
      cfg_r.dflt_backoff <= RST_PRUNE;
      cfg_r.extra_slots  <= RST_SLACK;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pbet_front #(
    .NUM_PEERS (NUM_PEERS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start && !clearing),
    .in_item    (in_item),
    .cfg        (cfg_r),
    .front_busy (front_busy),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  pbet_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_entry  (pop_entry)
  );

  pbet_back #(
    .NUM_PEERS (NUM_PEERS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_entry (pop_entry),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ===== sv/pbet_front.sv =====
// ---------------------------------------------------------------------------
// pbet_front: item intake and slot conversion
// Takes an item, classifies it, and for an update runs a restoring divider
// (one bit per cycle) over the backoff time and the default backoff, then
// clamps the slot count and pushes the work into the queue.
// ---------------------------------------------------------------------------
module pbet_front
  import pbet_pkg::*;
#(
  parameter int NUM_PEERS = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  in_item_t in_item,
  input  cfg_t     cfg,
  output logic     front_busy,
  output logic     push_valid,
  input  logic     push_ready,
  output q_entry_t push_entry
);

  localparam logic [1:0]  F_IDLE = 2'd0;
  localparam logic [1:0]  F_DIV  = 2'd1;
  localparam logic [1:0]  F_PUSH = 2'd2;
  localparam logic [12:0] NUM_PEERS_W = 13'(NUM_PEERS);
  localparam logic [4:0]  LAST_STEP = 5'(DIV_STEPS - 1);

  logic [1:0]  state_r, state_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [5:0]  peer_r, peer_nxt;
  logic [23:0] dvd_t_r, dvd_t_nxt;
  logic [23:0] dvd_p_r, dvd_p_nxt;
  logic [15:0] rem_t_r, rem_t_nxt;
  logic [15:0] rem_p_r, rem_p_nxt;
  logic [4:0]  cnt_r, cnt_nxt;

  logic [15:0] iv;
  logic [16:0] sh_t, sh_p;
  logic        ge_t, ge_p;
  logic        in_range;
  logic        accept;
  logic [1:0]  kind_in;
  logic [24:0] slots_t, span;

  assign iv         = eff_interval(cfg.hb_period);
  assign front_busy = (state_r != F_IDLE);
  assign accept     = start && (state_r == F_IDLE);
  assign in_range   = ({7'd0, in_item.peer_index} < NUM_PEERS_W);

  // Classify the incoming item
  always_comb begin
    case (in_item.action)
      ACT_TICK:   kind_in = KIND_TICK;
      ACT_QUERY:  kind_in = in_range ? KIND_QUERY : KIND_NOP;
      ACT_UPDATE: kind_in = in_range ? KIND_UPDATE : KIND_NOP;
      default:    kind_in = KIND_NOP;
    endcase
  end

  // One restoring division step for both dividends
  assign sh_t = {rem_t_r, dvd_t_r[23]};
  assign sh_p = {rem_p_r, dvd_p_r[23]};
  assign ge_t = (sh_t >= {1'b0, iv});
  assign ge_p = (sh_p >= {1'b0, iv});

  // Convert quotients to slots and clamp to the wheel span
  assign slots_t = {1'b0, dvd_t_r} + {17'd0, cfg.extra_slots};
  assign span    = {1'b0, dvd_p_r} + {17'd0, cfg.extra_slots};

  assign push_valid       = (state_r == F_PUSH);
  assign push_entry.kind  = kind_r;
  assign push_entry.peer  = peer_r;
  assign push_entry.slots = (slots_t > span) ? span : slots_t;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    peer_nxt  = peer_r;
    dvd_t_nxt = dvd_t_r;
    dvd_p_nxt = dvd_p_r;
    rem_t_nxt = rem_t_r;
    rem_p_nxt = rem_p_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          kind_nxt  = kind_in;
          peer_nxt  = in_item.peer_index;
          dvd_t_nxt = in_item.use_default ? cfg.dflt_backoff : in_item.backoff_time;
          dvd_p_nxt = cfg.dflt_backoff;
          rem_t_nxt = 16'd0;
          rem_p_nxt = 16'd0;
          cnt_nxt   = 5'd0;
          state_nxt = (kind_in == KIND_UPDATE) ? F_DIV : F_PUSH;
        end
      end
      F_DIV: begin
        rem_t_nxt = ge_t ? 16'(sh_t - {1'b0, iv}) : sh_t[15:0];
        rem_p_nxt = ge_p ? 16'(sh_p - {1'b0, iv}) : sh_p[15:0];
        dvd_t_nxt = {dvd_t_r[22:0], ge_t};
        dvd_p_nxt = {dvd_p_r[22:0], ge_p};
        cnt_nxt   = cnt_r + 5'd1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (push_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    kind_r  <= kind_nxt;
    peer_r  <= peer_nxt;
    dvd_t_r <= dvd_t_nxt;
    dvd_p_r <= dvd_p_nxt;
    rem_t_r <= rem_t_nxt;
    rem_p_r <= rem_p_nxt;
    cnt_r   <= cnt_nxt;
  end

endmodule

// ===== sv/pbet_queue.sv =====
// ---------------------------------------------------------------------------
// pbet_queue: two-entry work queue between front and back
// Lets the front finish the next item while the back is still busy.
// ---------------------------------------------------------------------------
module pbet_queue
  import pbet_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  q_entry_t push_entry,
  output logic     pop_valid,
  input  logic     pop,
  output q_entry_t pop_entry
);

  q_entry_t   slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_entry  = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== sv/pbet_back.sv =====
// ---------------------------------------------------------------------------
// pbet_back: expiry table and heartbeat counter
// Holds the per-peer absolute expiry memory and the heartbeat counter,
// carries out ticks, queries and updates in order, and drives the result.
// Clears the expiry memory one entry per cycle after reset.
// ---------------------------------------------------------------------------
module pbet_back
  import pbet_pkg::*;
#(
  parameter int NUM_PEERS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      pop_valid,
  input  q_entry_t  pop_entry,
  output logic      pop,
  output logic      clearing,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int PEER_AW = $clog2(NUM_PEERS);
  localparam logic [PEER_AW-1:0] LAST_IDX = PEER_AW'(NUM_PEERS - 1);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_EVAL = 2'd1;
  localparam logic [1:0] B_MUL  = 2'd2;
  localparam logic [1:0] B_FIN  = 2'd3;

  logic [31:0] mem [NUM_PEERS];

  logic [1:0]         state_r, state_nxt;
  logic [31:0]        hb_r, hb_nxt;
  logic               clr_r, clr_nxt;
  logic [PEER_AW-1:0] clr_idx_r, clr_idx_nxt;
  q_entry_t           cur_r, cur_nxt;
  logic [31:0]        rd_data_r;
  logic [31:0]        rem_r, rem_nxt;
  logic [31:0]        base_r, base_nxt;
  logic [47:0]        prod_r;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  logic [15:0]        iv;
  logic [31:0]        diff, rem;
  logic               upd_hit;
  logic               we;
  logic [PEER_AW-1:0] waddr, raddr;
  logic [31:0]        wdata;

  assign iv        = eff_interval(cfg.hb_period);
  assign clearing  = clr_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign pop       = (state_r == B_IDLE) && pop_valid && !clr_r;
  assign raddr     = PEER_AW'(pop_entry.peer);

  // Remaining slots under the wrapped signed compare
  assign diff    = rd_data_r - hb_r;
  assign rem     = ((diff != 32'd0) && !diff[31]) ? diff : 32'd0;
  assign upd_hit = (cur_r.kind == KIND_UPDATE) && (cur_r.slots != 25'd0)
                   && ({7'd0, cur_r.slots} > rem);

  // Single write port: clearing pass or expiry extension
  always_comb begin
    we    = 1'b0;
    waddr = clr_idx_r;
    wdata = 32'd0;
    if (clr_r) begin
      we = 1'b1;
    end else if ((state_r == B_EVAL) && upd_hit) begin
      we    = 1'b1;
      waddr = PEER_AW'(cur_r.peer);
      wdata = hb_r + {7'd0, cur_r.slots};
    end
  end

  // Sequence one queued item
  always_comb begin
    state_nxt     = state_r;
    hb_nxt        = hb_r;
    clr_nxt       = clr_r;
    clr_idx_nxt   = clr_idx_r;
    cur_nxt       = cur_r;
    rem_nxt       = rem_r;
    base_nxt      = base_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    if (clr_r) begin
      clr_idx_nxt = clr_idx_r + PEER_AW'(1);
      if (clr_idx_r == LAST_IDX) begin
        clr_nxt = 1'b0;
      end
    end
    case (state_r)
      B_IDLE: begin
        if (pop) begin
          cur_nxt   = pop_entry;
          state_nxt = B_EVAL;
        end
      end
      B_EVAL: begin
        if (cur_r.kind == KIND_QUERY) begin
          rem_nxt   = rem;
          base_nxt  = (rem > {24'd0, cfg.extra_slots}) ?
                      rem - {24'd0, cfg.extra_slots} : 32'd0;
          state_nxt = B_MUL;
        end else begin
          if (cur_r.kind == KIND_TICK) begin
            hb_nxt = hb_r + 32'd1;
          end
          out_item_nxt  = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = B_IDLE;
        end
      end
      B_MUL: begin
        state_nxt = B_FIN;
      end
      B_FIN: begin
        out_item_nxt.remaining_slots = rem_r;
        out_item_nxt.remaining_time  = (prod_r[47:32] != 16'd0) ? 32'hFFFF_FFFF
                                                                : prod_r[31:0];
        out_item_nxt.in_backoff      = (rem_r != 32'd0);
        out_valid_nxt                = 1'b1;
        state_nxt                    = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      hb_r        <= 32'd0;
      clr_r       <= 1'b1;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hb_r        <= hb_nxt;
      clr_r       <= clr_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r      <= cur_nxt;
    rem_r      <= rem_nxt;
    base_r     <= base_nxt;
    prod_r     <= base_r * iv;
    out_item_r <= out_item_nxt;
  end

  // Expiry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[raddr];
  end

endmodule

// ===== sv/pbet_checker.sv =====
// ---------------------------------------------------------------------------
// pbet_checker: port-level checks for the peer backoff expiry table
// Watches the command and result ports and flags broken behavior.
// ---------------------------------------------------------------------------
module pbet_checker
  import pbet_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);

  // Hold off items while the clearing pass starts
  a_busy_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  // Taking an item makes the block busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("not busy after item accepted");

  // Results never come in back-to-back cycles
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held two cycles");

  // Flag agrees with remaining slots
  a_flag_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.in_backoff == (out_item.remaining_slots != 32'd0)))
    else $error("in_backoff disagrees with remaining_slots");

  // No backoff time without pending slots
  a_time_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.in_backoff) |-> (out_item.remaining_time == 32'd0))
    else $error("remaining_time set without backoff");

endmodule

bind peer_backoff_expiry_table pbet_checker u_pbet_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the peer backoff expiry table
// Sends heartbeat ticks, peer queries and backoff updates with random gaps
// and bursts, under several register settings. A local copy of the heartbeat
// counter, the expiry table and the registers predicts every answer. Each
// result strobe is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import pbet_pkg::*;

  localparam int NUM_PEERS = 64;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int MAX_GAP = 17;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS = 250;
  localparam int NUM_PHASES = 7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_item = '0;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_IDX_INTERVAL;
  logic [23:0] cfg_data = '0;

  // Local copy of the block's state and registers
  logic [31:0] hb_count;
  logic [31:0] expiry_slot [NUM_PEERS];
  logic [15:0] interval_reg;
  logic [23:0] prune_reg;
  logic [7:0]  slack_reg;

  out_item_t   expected_answers [$];
  out_item_t   oldest_answer;
  int          failures = 0;
  int          stall_cycles = 0;
  bit          start_held = 1'b0;
  bit          no_gaps = 1'b0;
  int          next_gap = 0;

  peer_backoff_expiry_table #(
    .NUM_PEERS(NUM_PEERS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Expiry predictor
  // ---------------------------------------------------------------------------
  task automatic clear_table();
    hb_count = '0;
    for (int p = 0; p < NUM_PEERS; p++) expiry_slot[p] = '0;
    interval_reg = RST_INTERVAL;
    prune_reg = RST_PRUNE;
    slack_reg = RST_SLACK;
  endtask

  // A zero interval divides and multiplies as one
  function automatic logic [31:0] active_interval();
    return (interval_reg == 16'd0) ? 32'd1 : {16'd0, interval_reg};
  endfunction

  // Wrapped distance to expiry; a negative signed distance means lapsed
  function automatic logic [31:0] slots_left(input logic [5:0] peer);
    logic [31:0] diff;
    diff = expiry_slot[peer] - hb_count;
    return (diff != 32'd0 && !diff[31]) ? diff : 32'd0;
  endfunction

  function automatic out_item_t apply_event(input in_item_t it);
    out_item_t   res;
    logic [31:0] rem;
    logic [31:0] base;
    logic [31:0] req;
    logic [31:0] slots;
    logic [31:0] span;
    logic [63:0] prod;
    res = '0;
    case (it.action)
      ACT_TICK: hb_count = hb_count + 32'd1;
      ACT_QUERY: begin
        rem = slots_left(it.peer_index);
        base = (rem > {24'd0, slack_reg}) ? rem - {24'd0, slack_reg} : 32'd0;
        prod = {32'd0, base} * {32'd0, active_interval()};
        res.remaining_slots = rem;
        res.remaining_time = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
        res.in_backoff = (rem != 32'd0);
      end
      ACT_UPDATE: begin
        // Convert time to slots, clamp to the wheel span, only ever extend
        req = it.use_default ? {8'd0, prune_reg} : {8'd0, it.backoff_time};
        slots = req / active_interval() + {24'd0, slack_reg};
        span = {8'd0, prune_reg} / active_interval() + {24'd0, slack_reg};
        if (slots > span) slots = span;
        if (slots != 32'd0 && slots > slots_left(it.peer_index))
          expiry_slot[it.peer_index] = hb_count + slots;
      end
      default: ;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result check: compare each strobe with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_answers.size() == 0) begin
        $error("result strobe with no item outstanding");
        failures++;
      end else begin
        oldest_answer = expected_answers.pop_front();
        if (out_item.remaining_slots !== oldest_answer.remaining_slots) begin
          $error("remaining_slots: expected %0d, actual %0d",
                 oldest_answer.remaining_slots, out_item.remaining_slots);
          failures++;
        end
        if (out_item.remaining_time !== oldest_answer.remaining_time) begin
          $error("remaining_time: expected %0d, actual %0d",
                 oldest_answer.remaining_time, out_item.remaining_time);
          failures++;
        end
        if (out_item.in_backoff !== oldest_answer.in_backoff) begin
          $error("in_backoff: expected %0b, actual %0b",
                 oldest_answer.in_backoff, out_item.in_backoff);
          failures++;
        end
      end
    end
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk) begin
    if ((start && !busy) || (cfg_valid && cfg_ready) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Drop start if it was left high for a back-to-back item
  task automatic release_start();
    if (start_held) begin
      start <= 1'b0;
      start_held = 1'b0;
    end
  endtask

  // Send one item, predict its answer, draw the gap before the next one
  task automatic send_item(input in_item_t it);
    if (!start_held) begin
      repeat (next_gap) @(posedge clk);
      start <= 1'b1;
    end
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_answers.push_back(apply_event(it));
    next_gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    if (next_gap == 0) begin
      start_held = 1'b1;
    end else begin
      start <= 1'b0;
      start_held = 1'b0;
    end
  endtask

  // Hold the sender until every outstanding answer has come back
  task automatic wait_drained();
    release_start();
    do @(posedge clk); while (expected_answers.size() != 0);
  endtask

  // Write all three registers while the table is idle
  task automatic write_config(input logic [15:0] interval, input logic [23:0] prune,
                              input logic [7:0] slack);
    logic [23:0] vals [3];
    logic [1:0]  idx [3];
    wait_drained();
    vals = '{{8'd0, interval}, prune, {16'd0, slack}};
    idx = '{CFG_IDX_INTERVAL, CFG_IDX_PRUNE, CFG_IDX_SLACK};
    cfg_valid <= 1'b1;
    for (int k = 0; k < 3; k++) begin
      cfg_index <= idx[k];
      cfg_data <= vals[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    interval_reg = interval;
    prune_reg = prune;
    slack_reg = slack;
  endtask

  function automatic in_item_t event_item(input logic [1:0] action, input int peer,
                                          input logic [23:0] btime, input bit use_def);
    in_item_t it;
    it.action = action;
    it.peer_index = 6'(peer);
    it.backoff_time = btime;
    it.use_default = use_def;
    return it;
  endfunction

  // Mostly a few busy peers so updates and queries meet; times near the span
  function automatic in_item_t random_event();
    in_item_t    it;
    int unsigned pick;
    logic [31:0] span_time;
    pick = $urandom_range(0, 99);
    if (pick < 3) it.action = ACT_UNUSED;
    else if (pick < 38) it.action = ACT_TICK;
    else if (pick < 70) it.action = ACT_QUERY;
    else it.action = ACT_UPDATE;
    it.peer_index = ($urandom_range(0, 4) != 0) ? 6'($urandom_range(0, 7))
                                                : 6'($urandom_range(0, 63));
    case ($urandom_range(0, 9))
      0, 1, 2: it.backoff_time = 24'($urandom);
      3, 4:    it.backoff_time = 24'($urandom_range(0, 3 * active_interval()));
      default: begin
        span_time = {8'd0, prune_reg} + 4 * active_interval();
        if (span_time > 32'h00FF_FFFF) span_time = 32'h00FF_FFFF;
        it.backoff_time = 24'($urandom_range(0, span_time));
      end
    endcase
    it.use_default = ($urandom_range(0, 3) == 0);
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Peers at both ends of the table read as free after reset
  task automatic test_idle_table();
    send_item(event_item(ACT_QUERY, 0, 24'd0, 1'b0));
    send_item(event_item(ACT_QUERY, NUM_PEERS - 1, 24'hFF_FFFF, 1'b1));
  endtask

  // Default backoff, clamped and minimal updates, then count them down
  task automatic test_update_countdown();
    send_item(event_item(ACT_UPDATE, 5, 24'd0, 1'b1));
    send_item(event_item(ACT_QUERY, 5, 24'd0, 1'b0));
    send_item(event_item(ACT_TICK, 0, 24'd0, 1'b0));
    send_item(event_item(ACT_QUERY, 5, 24'd0, 1'b0));
    send_item(event_item(ACT_UPDATE, NUM_PEERS - 1, 24'hFF_FFFF, 1'b0));
    send_item(event_item(ACT_UPDATE, 0, 24'd0, 1'b0));
    send_item(event_item(ACT_QUERY, 0, 24'd0, 1'b0));
    send_item(event_item(ACT_TICK, NUM_PEERS - 1, 24'hFF_FFFF, 1'b1));
    send_item(event_item(ACT_QUERY, 0, 24'd0, 1'b0));
    send_item(event_item(ACT_QUERY, NUM_PEERS - 1, 24'd0, 1'b0));
  endtask

  // A backoff shorter than what is left leaves the expiry alone
  task automatic test_shorter_backoff();
    send_item(event_item(ACT_UPDATE, 5, 24'd2000, 1'b0));
    send_item(event_item(ACT_QUERY, 5, 24'd0, 1'b0));
  endtask

  task automatic test_unused_action();
    send_item(event_item(ACT_UNUSED, NUM_PEERS - 1, 24'hFF_FFFF, 1'b1));
    send_item(event_item(ACT_QUERY, 5, 24'd0, 1'b0));
  endtask

  // Zero span: every update rounds to no slots and is dropped
  task automatic test_zero_slots();
    write_config(16'hFFFF, 24'd100, 8'd0);
    send_item(event_item(ACT_UPDATE, 1, 24'd0, 1'b1));
    send_item(event_item(ACT_UPDATE, 1, 24'hFF_FFFF, 1'b0));
    send_item(event_item(ACT_QUERY, 1, 24'd0, 1'b0));
  endtask

  task automatic test_zero_interval();
    write_config(16'd0, 24'd10, 8'd2);
    send_item(event_item(ACT_UPDATE, 2, 24'd5, 1'b0));
    send_item(event_item(ACT_QUERY, 2, 24'd0, 1'b0));
  endtask

  // Longest backoff at interval one, read back at the largest interval
  task automatic test_time_saturation();
    write_config(16'd1, 24'hFF_FFFF, 8'hFF);
    send_item(event_item(ACT_UPDATE, 3, 24'd0, 1'b1));
    wait_drained();
    write_config(16'hFFFF, 24'hFF_FFFF, 8'hFF);
    send_item(event_item(ACT_QUERY, 3, 24'd0, 1'b0));
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: write_config(RST_INTERVAL, RST_PRUNE, RST_SLACK);
        1: write_config(16'd1, 24'($urandom_range(0, 200)), 8'd0);
        2: write_config(16'hFFFF, 24'hFF_FFFF, 8'hFF);
        3: write_config(16'd0, 24'($urandom_range(0, 500)), 8'($urandom_range(0, 3)));
        4: write_config(16'($urandom_range(1, 50)), 24'($urandom_range(0, 5000)),
                        8'($urandom_range(0, 5)));
        5: write_config(16'($urandom), 24'($urandom), 8'($urandom));
        default: write_config(16'd7, 24'd0, 8'd0);
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
        if ($urandom_range(0, 59) == 0) wait_drained();
        send_item(random_event());
      end
    end
  endtask

  initial begin
    clear_table();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_table();
    test_update_countdown();
    test_shorter_backoff();
    test_unused_action();
    test_zero_slots();
    test_zero_interval();
    test_time_saturation();
    test_random_traffic();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
